### rtl/core/rmms_pkg.sv
// shared constants and types for the running min/max/mean/std-dev monitor
package rmms_pkg;

    localparam int OUT_VALUE_BITS = 16;
    localparam int OUT_TIME_BITS  = 48;
    localparam int OUT_COUNT_BITS = 32;
    localparam int Q_BITS         = 24;
    localparam int FRAC_BITS      = 8;
    localparam int SUMSQ_BITS     = 64;
    localparam int SQ_SHIFT       = 16;
    localparam int DIV_BITS       = SUMSQ_BITS + SQ_SHIFT;
    localparam int ROOT_STEPS     = SUMSQ_BITS / 2;

    localparam logic [Q_BITS-1:0]     MEAN_POS_MAX   = 24'h7F_FFFF;
    localparam logic [Q_BITS-1:0]     MEAN_NEG_MIN   = 24'h80_0000;
    localparam logic [Q_BITS-1:0]     SD_MAX         = 24'hFF_FFFF;
    localparam logic [SUMSQ_BITS-1:0] MEAN_POS_LIMIT = 64'd8388607;
    localparam logic [SUMSQ_BITS-1:0] MEAN_NEG_LIMIT = 64'd8388608;
    localparam logic [SUMSQ_BITS-1:0] ROOT_BIT_INIT  = 64'h4000_0000_0000_0000;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_DIV_SQ,
        ST_MUL,
        ST_DIFF,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

### rtl/core/rmms_ifs.sv
// request and result channel interfaces of the statistics monitor
interface rmms_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 48
);
    import rmms_pkg::*;

    logic                          valid;
    logic                          ready;
    op_t                           operation;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]          timestamp;

    modport source (output valid, operation, sample, timestamp, input ready);
    modport sink   (input valid, operation, sample, timestamp, output ready);
endinterface

interface rmms_out_if;
    import rmms_pkg::*;

    logic                             valid;
    logic                             ready;
    logic                             has_data;
    logic signed [OUT_VALUE_BITS-1:0] max_value;
    logic [OUT_TIME_BITS-1:0]         max_time;
    logic signed [OUT_VALUE_BITS-1:0] min_value;
    logic [OUT_TIME_BITS-1:0]         min_time;
    logic signed [Q_BITS-1:0]         mean_q8;
    logic [Q_BITS-1:0]                std_dev_q8;
    logic [OUT_COUNT_BITS-1:0]        sample_count;
    logic                             count_saturated;

    modport source (output valid, has_data, max_value, max_time, min_value, min_time,
                    mean_q8, std_dev_q8, sample_count, count_saturated, input ready);
    modport sink   (input valid, has_data, max_value, max_time, min_value, min_time,
                    mean_q8, std_dev_q8, sample_count, count_saturated, output ready);
endinterface

### rtl/core/running_min_max_mean_stddev.sv
// running min/max/mean/std-dev monitor: top level with shared divide/square-root sequencer
//
// samples channel: one request per sample (operation add) or clear (operation clear).
// stats channel: exactly one result per request, the statistics after its update.
// cfg_write/cfg_data set std_dev_enable; write only while no request is in flight.
// one request is worked on at a time; samples.ready is high only while idle.
// the work is done by one shared restoring divider (one quotient bit a cycle,
// first the mean, then the 80-bit scaled sum of squares) and a square root
// that resolves one result bit a cycle; one shared multiplier squares the sample
// and the mean. with std_dev_enable low the second divide and the root are skipped;
// when the statistics are empty after the update, both divides and the root are.
// samples.ready returns as the result is registered, together with stats.valid.
// the result sits in an output register; a stalled receiver holds it there, one
// more request is taken and worked on, then the block waits with samples.ready low.
// reset clears all statistics and sets std_dev_enable to 1.
module running_min_max_mean_stddev #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32,
    parameter int TIME_BITS   = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_data,
    rmms_in_if.sink           samples,
    rmms_out_if.source        stats
);
    import rmms_pkg::*;

    localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
    localparam int MEAN_DIV_BITS = SUM_BITS + FRAC_BITS;
    localparam int MUL_BITS      = SAMPLE_BITS + FRAC_BITS;
    localparam int ITER_W        = $clog2(DIV_BITS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    state_t state_reg, state_next;

    // statistics state
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SUMSQ_BITS-1:0]         sumsq_reg, sumsq_next;
    logic signed [SAMPLE_BITS-1:0] largest_reg, largest_next;
    logic signed [SAMPLE_BITS-1:0] smallest_reg, smallest_next;
    logic [TIME_BITS-1:0]          largest_time_reg, largest_time_next;
    logic [TIME_BITS-1:0]          smallest_time_reg, smallest_time_next;
    logic                          std_en_reg;

    // working registers
    op_t                           op_reg, op_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [TIME_BITS-1:0]          time_reg, time_next;
    logic [2*MUL_BITS-1:0]         prod_reg, prod_next;
    logic [DIV_BITS-1:0]           div_d_reg, div_d_next;
    logic [COUNT_BITS-1:0]         div_r_reg, div_r_next;
    logic [ITER_W-1:0]             iter_reg, iter_next;
    logic                          neg_reg, neg_next;
    logic [MUL_BITS-1:0]           mag_q_reg, mag_q_next;
    logic [Q_BITS-1:0]             mean_reg, mean_next;
    logic [SUMSQ_BITS-1:0]         ms_reg, ms_next;
    logic [SUMSQ_BITS-1:0]         root_v_reg, root_v_next;
    logic [SUMSQ_BITS-1:0]         root_res_reg, root_res_next;
    logic [SUMSQ_BITS-1:0]         root_bit_reg, root_bit_next;
    logic [Q_BITS-1:0]             sd_reg, sd_next;

    // result register
    logic                             out_valid_reg, out_valid_next;
    logic                             has_data_reg;
    logic signed [OUT_VALUE_BITS-1:0] max_value_reg, min_value_reg;
    logic [OUT_TIME_BITS-1:0]         max_time_reg, min_time_reg;
    logic [Q_BITS-1:0]                mean_out_reg, sd_out_reg;
    logic [OUT_COUNT_BITS-1:0]        count_out_reg;
    logic                             sat_out_reg;

    logic in_ready;
    logic result_load;
    logic in_accept;

    // shared multiplier
    logic signed [MUL_BITS-1:0] samp_ext;
    logic [MUL_BITS-1:0]        samp_mag;
    logic [MUL_BITS-1:0]        mul_a;
    logic [2*MUL_BITS-1:0]      mul_prod;

    // shared divider step
    logic [COUNT_BITS:0] div_trial;
    logic [COUNT_BITS:0] div_diff;
    logic                div_ge;
    logic [DIV_BITS-1:0] div_d_step;
    logic [COUNT_BITS-1:0] div_r_step;

    // square root step
    logic [SUMSQ_BITS-1:0] root_trial;
    logic                  root_ge;
    logic [SUMSQ_BITS-1:0] root_res_step;

    logic [SUM_BITS-1:0]      sum_mag;
    logic [MEAN_DIV_BITS-1:0] q_corr;
    logic [Q_BITS-1:0]        q_low;
    logic [SUMSQ_BITS:0]      sumsq_add;
    logic [SUMSQ_BITS-1:0]    mm;

    logic signed [63:0] largest_wide, smallest_wide;
    logic [63:0]        largest_time_wide, smallest_time_wide;

    assign in_accept = samples.valid && in_ready;

    assign samp_ext = MUL_BITS'(sample_reg);
    assign samp_mag = samp_ext[MUL_BITS-1] ? MUL_BITS'(-samp_ext) : MUL_BITS'(samp_ext);
    assign mul_a    = (state_reg == ST_SQUARE) ? samp_mag : mag_q_reg;
    assign mul_prod = (2*MUL_BITS)'(mul_a) * (2*MUL_BITS)'(mul_a);

    assign div_trial  = {div_r_reg, div_d_reg[DIV_BITS-1]};
    assign div_diff   = div_trial - {1'b0, count_reg};
    assign div_ge     = div_trial >= {1'b0, count_reg};
    assign div_r_step = div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
    assign div_d_step = {div_d_reg[DIV_BITS-2:0], div_ge};

    assign root_trial    = root_res_reg + root_bit_reg;
    assign root_ge       = root_v_reg >= root_trial;
    assign root_res_step = root_ge ? (root_res_reg >> 1) + root_bit_reg : root_res_reg >> 1;

    assign sum_mag   = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    // floor for a negative mean means rounding the magnitude up
    assign q_corr    = div_d_reg[MEAN_DIV_BITS-1:0]
                     + MEAN_DIV_BITS'(neg_reg && (div_r_reg != '0));
    assign q_low     = Q_BITS'(q_corr);
    assign sumsq_add = {1'b0, sumsq_reg} + {1'b0, SUMSQ_BITS'(prod_reg)};
    assign mm        = SUMSQ_BITS'(prod_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_LOAD;
            ST_LOAD:
            begin
                state_next = (count_reg == '0) ? ST_DONE : ST_DIV_MEAN;
            end
            ST_DIV_MEAN:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                state_next = std_en_reg ? ST_DIV_SQ : ST_DONE;
            end
            ST_DIV_SQ:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        result_load = (state_reg == ST_DONE) && (!out_valid_reg || stats.ready);
    end

    // datapath
    always_comb
    begin
        count_next         = count_reg;
        sum_next           = sum_reg;
        sumsq_next         = sumsq_reg;
        largest_next       = largest_reg;
        smallest_next      = smallest_reg;
        largest_time_next  = largest_time_reg;
        smallest_time_next = smallest_time_reg;
        op_next            = op_reg;
        sample_next        = sample_reg;
        time_next          = time_reg;
        prod_next          = prod_reg;
        div_d_next         = div_d_reg;
        div_r_next         = div_r_reg;
        iter_next          = iter_reg;
        neg_next           = neg_reg;
        mag_q_next         = mag_q_reg;
        mean_next          = mean_reg;
        ms_next            = ms_reg;
        root_v_next        = root_v_reg;
        root_res_next      = root_res_reg;
        root_bit_next      = root_bit_reg;
        sd_next            = sd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = samples.operation;
                    sample_next = samples.sample;
                    time_next   = samples.timestamp;
                end
            end
            ST_SQUARE:
            begin
                prod_next = mul_prod;
            end
            ST_UPDATE:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    count_next         = '0;
                    sum_next           = '0;
                    sumsq_next         = '0;
                    largest_next       = '0;
                    smallest_next      = '0;
                    largest_time_next  = '0;
                    smallest_time_next = '0;
                end
                else
                begin
                    if ((count_reg == '0) || (sample_reg > largest_reg))
                    begin
                        largest_next      = sample_reg;
                        largest_time_next = time_reg;
                    end
                    if ((count_reg == '0) || (sample_reg < smallest_reg))
                    begin
                        smallest_next      = sample_reg;
                        smallest_time_next = time_reg;
                    end
                    // sums freeze once the count is saturated
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                        sum_next   = sum_reg + SUM_BITS'(sample_reg);
                        sumsq_next = sumsq_add[SUMSQ_BITS] ? {SUMSQ_BITS{1'b1}}
                                                           : sumsq_add[SUMSQ_BITS-1:0];
                    end
                end
            end
            ST_LOAD:
            begin
                mean_next  = '0;
                sd_next    = '0;
                neg_next   = sum_reg[SUM_BITS-1];
                div_r_next = '0;
                div_d_next = DIV_BITS'({sum_mag, {FRAC_BITS{1'b0}}})
                             << (DIV_BITS - MEAN_DIV_BITS);
                iter_next  = ITER_W'(MEAN_DIV_BITS - 1);
            end
            ST_DIV_MEAN, ST_DIV_SQ:
            begin
                div_d_next = div_d_step;
                div_r_next = div_r_step;
                iter_next  = iter_reg - ITER_W'(1);
            end
            ST_MEAN:
            begin
                mag_q_next = MUL_BITS'(q_corr);
                if (neg_reg)
                begin
                    mean_next = (SUMSQ_BITS'(q_corr) > MEAN_NEG_LIMIT) ? MEAN_NEG_MIN
                                                                       : Q_BITS'(0) - q_low;
                end
                else
                begin
                    mean_next = (SUMSQ_BITS'(q_corr) > MEAN_POS_LIMIT) ? MEAN_POS_MAX : q_low;
                end
                div_r_next = '0;
                div_d_next = {sumsq_reg, {SQ_SHIFT{1'b0}}};
                iter_next  = ITER_W'(DIV_BITS - 1);
            end
            ST_MUL:
            begin
                prod_next = mul_prod;
                ms_next   = (div_d_reg[DIV_BITS-1:SUMSQ_BITS] != '0) ? {SUMSQ_BITS{1'b1}}
                                                                    : div_d_reg[SUMSQ_BITS-1:0];
            end
            ST_DIFF:
            begin
                root_v_next   = (ms_reg >= mm) ? ms_reg - mm : mm - ms_reg;
                root_res_next = '0;
                root_bit_next = ROOT_BIT_INIT;
                iter_next     = ITER_W'(ROOT_STEPS - 1);
            end
            ST_ROOT:
            begin
                root_v_next   = root_ge ? root_v_reg - root_trial : root_v_reg;
                root_res_next = root_res_step;
                root_bit_next = root_bit_reg >> 2;
                iter_next     = iter_reg - ITER_W'(1);
                if (iter_reg == '0)
                begin
                    sd_next = (root_res_step > SUMSQ_BITS'(SD_MAX)) ? SD_MAX
                                                                    : Q_BITS'(root_res_step);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = result_load ? 1'b1 : (stats.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            std_en_reg        <= 1'b1;
            count_reg         <= '0;
            sum_reg           <= '0;
            sumsq_reg         <= '0;
            largest_reg       <= '0;
            smallest_reg      <= '0;
            largest_time_reg  <= '0;
            smallest_time_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_write)
            begin
                std_en_reg <= cfg_data;
            end
            count_reg         <= count_next;
            sum_reg           <= sum_next;
            sumsq_reg         <= sumsq_next;
            largest_reg       <= largest_next;
            smallest_reg      <= smallest_next;
            largest_time_reg  <= largest_time_next;
            smallest_time_reg <= smallest_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        sample_reg   <= sample_next;
        time_reg     <= time_next;
        prod_reg     <= prod_next;
        div_d_reg    <= div_d_next;
        div_r_reg    <= div_r_next;
        iter_reg     <= iter_next;
        neg_reg      <= neg_next;
        mag_q_reg    <= mag_q_next;
        mean_reg     <= mean_next;
        ms_reg       <= ms_next;
        root_v_reg   <= root_v_next;
        root_res_reg <= root_res_next;
        root_bit_reg <= root_bit_next;
        sd_reg       <= sd_next;
    end

    assign largest_wide       = 64'(largest_reg);
    assign smallest_wide      = 64'(smallest_reg);
    assign largest_time_wide  = 64'(largest_time_reg);
    assign smallest_time_wide = 64'(smallest_time_reg);

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            has_data_reg  <= (count_reg != '0);
            max_value_reg <= largest_wide[OUT_VALUE_BITS-1:0];
            max_time_reg  <= largest_time_wide[OUT_TIME_BITS-1:0];
            min_value_reg <= smallest_wide[OUT_VALUE_BITS-1:0];
            min_time_reg  <= smallest_time_wide[OUT_TIME_BITS-1:0];
            mean_out_reg  <= mean_reg;
            sd_out_reg    <= sd_reg;
            count_out_reg <= OUT_COUNT_BITS'(count_reg);
            sat_out_reg   <= (count_reg == COUNT_MAX);
        end
    end

    assign samples.ready         = in_ready;
    assign stats.valid           = out_valid_reg;
    assign stats.has_data        = has_data_reg;
    assign stats.max_value       = max_value_reg;
    assign stats.max_time        = max_time_reg;
    assign stats.min_value       = min_value_reg;
    assign stats.min_time        = min_time_reg;
    assign stats.mean_q8         = mean_out_reg;
    assign stats.std_dev_q8      = sd_out_reg;
    assign stats.sample_count    = count_out_reg;
    assign stats.count_saturated = sat_out_reg;

endmodule

### rtl/core/rmms_checker.sv
// port-level checker for the statistics monitor, bound to the top level
module rmms_checker (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      in_valid,
    input logic                                      in_ready,
    input logic                                      out_valid,
    input logic                                      out_ready,
    input logic                                      has_data,
    input logic signed [rmms_pkg::OUT_VALUE_BITS-1:0] max_value,
    input logic signed [rmms_pkg::OUT_VALUE_BITS-1:0] min_value,
    input logic signed [rmms_pkg::Q_BITS-1:0]         mean_q8,
    input logic [rmms_pkg::Q_BITS-1:0]                std_dev_q8,
    input logic [rmms_pkg::OUT_COUNT_BITS-1:0]        sample_count,
    input logic                                      count_saturated
);
    import rmms_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mean_q8) && $stable(std_dev_q8)
                                    && $stable(sample_count))
        else $error("stalled result changed");

    // only one request in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // empty statistics read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> max_value == '0 && min_value == '0 && mean_q8 == '0
                                   && std_dev_q8 == '0 && sample_count == '0)
        else $error("empty statistics not zero");

    // saturation and count agree
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_saturated |-> has_data && sample_count != '0)
        else $error("saturated flag without samples");

endmodule

bind running_min_max_mean_stddev rmms_checker u_rmms_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (samples.valid),
    .in_ready        (samples.ready),
    .out_valid       (stats.valid),
    .out_ready       (stats.ready),
    .has_data        (stats.has_data),
    .max_value       (stats.max_value),
    .min_value       (stats.min_value),
    .mean_q8         (stats.mean_q8),
    .std_dev_q8      (stats.std_dev_q8),
    .sample_count    (stats.sample_count),
    .count_saturated (stats.count_saturated)
);
